### sv/hue_range_alpha_key_defines.svh
// assertion macros for the hue range alpha key block
// used by the top level only; no other dependencies
`ifndef HUE_RANGE_ALPHA_KEY_DEFINES_SVH
`define HUE_RANGE_ALPHA_KEY_DEFINES_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define HRAK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hrak assertion failed");

// consequent must hold in the cycle after the antecedent
`define HRAK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrak assertion failed");

`else

`define HRAK_ASSERT(lbl, prop)
`define HRAK_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### sv/hrak_pkg.sv
// types and constants for the hue range alpha key pipeline
// no dependencies
package hrak_pkg;

    // hue scale: 256 units per degree
    localparam logic [16:0] HUE_SIXTY = 17'd15360;
    localparam logic [16:0] HUE_FULL  = 17'd92160;
    localparam logic [16:0] HUE_BASE_RED   = 17'd0;
    localparam logic [16:0] HUE_BASE_GREEN = 17'd30720;
    localparam logic [16:0] HUE_BASE_BLUE  = 17'd61440;

    // configuration register indexes and reset values
    localparam logic REG_HUE_LOW  = 1'b0;
    localparam logic REG_HUE_HIGH = 1'b1;
    localparam logic [16:0] HUE_LOW_RESET  = 17'd36148;
    localparam logic [16:0] HUE_HIGH_RESET = 17'd36172;

    // alpha codes
    localparam logic [7:0] ALPHA_KEYED  = 8'd0;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // sector codes, by which channel holds the maximum
    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    // divider geometry: quotient below 16384, two bits per stage
    localparam int QUO_W        = 14;
    localparam int DIV_BITS     = 2;
    localparam int DIV_STAGES   = QUO_W / DIV_BITS;
    // front stages (sort, scale), divider stages, hue stage
    localparam int DIV_PIPE     = 2 + DIV_STAGES;
    localparam int NUM_STAGES   = DIV_PIPE + 1;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [7:0]  alpha_out;
        logic [16:0] hue_out;
    } result_t;

    // contents of one front or divider stage
    typedef struct packed {
        pixel_t            pix;
        logic [1:0]        sector;
        logic              neg;
        logic              zero;
        logic [7:0]        delta;
        logic [7:0]        mag;
        logic [7:0]        rem;
        logic [QUO_W-1:0]  dvd;
        logic [QUO_W-1:0]  quo;
    } div_t;

endpackage

### sv/hue_range_alpha_key.sv
// a result reaches res_data through 11 registers:
// sort, scale, 7 divider stages, hue, output
// throughput: one pixel per cycle barring stalls; 7-stage radix-4 divider, fully pipelined
// a stall on the result side holds only the stages that are full; bubbles close up
// reset: rst_n clears all valid bits and loads the hue bounds with 36148 and 36172
// depends on hrak_pkg and hue_range_alpha_key_defines.svh
`include "hue_range_alpha_key_defines.svh"

module hue_range_alpha_key (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pix_valid,
    output logic             pix_stall,
    input  hrak_pkg::pixel_t pix_data,
    output logic             res_valid,
    input  logic             res_stall,
    output hrak_pkg::result_t res_data,
    input  logic             wr_en,
    input  logic             wr_index,
    input  logic [16:0]      wr_data
);
    import hrak_pkg::*;

    // one restoring division step on the 9-bit trial remainder
    function automatic div_t div_step(div_t s);
        logic [8:0] trial;
        div_t       o;
        o     = s;
        trial = {s.rem, s.dvd[QUO_W-1]};
        o.dvd = {s.dvd[QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, s.delta})
        begin
            o.rem = 8'(trial - {1'b0, s.delta});
            o.quo = {s.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = trial[7:0];
            o.quo = {s.quo[QUO_W-2:0], 1'b0};
        end
        return o;
    endfunction

    logic [16:0] hue_low_reg;
    logic [16:0] hue_high_reg;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES:0]   en;

    div_t stg_reg  [DIV_PIPE];
    div_t stg_next [DIV_PIPE];

    pixel_t      hue_pix_reg;
    logic [16:0] hue_reg;
    logic [16:0] hue_next;

    logic    res_valid_reg;
    result_t res_reg;
    result_t res_next;

    // temporaries for the sort, scale and hue stages
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  op_a;
    logic [7:0]  op_b;
    logic [21:0] scaled;
    logic [16:0] base;
    logic [16:0] quo_ext;
    div_t        last;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_low_reg  <= HUE_LOW_RESET;
            hue_high_reg <= HUE_HIGH_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_HUE_LOW:  hue_low_reg  <= wr_data;
                REG_HUE_HIGH: hue_high_reg <= wr_data;
                default:      ;
            endcase
        end
    end

    // stage enables: a stage moves when empty or when the next one moves
    always_comb
    begin
        en[NUM_STAGES] = !res_valid_reg || !res_stall;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign pix_stall = !en[0];

    // valid bits travel with the data
    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = pix_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    // first stage: max, min, sector and difference magnitude
    always_comb
    begin
        mx = pix_data.red_in;
        mn = pix_data.red_in;
        if (pix_data.green_in > mx) mx = pix_data.green_in;
        if (pix_data.blue_in > mx)  mx = pix_data.blue_in;
        if (pix_data.green_in < mn) mn = pix_data.green_in;
        if (pix_data.blue_in < mn)  mn = pix_data.blue_in;

        stg_next[0]       = '0;
        stg_next[0].pix   = pix_data;
        stg_next[0].delta = mx - mn;
        stg_next[0].zero  = (mx == mn);
        if (pix_data.red_in == mx)
        begin
            stg_next[0].sector = SEC_RED;
            op_a = pix_data.green_in;
            op_b = pix_data.blue_in;
        end
        else if (pix_data.green_in == mx)
        begin
            stg_next[0].sector = SEC_GREEN;
            op_a = pix_data.blue_in;
            op_b = pix_data.red_in;
        end
        else
        begin
            stg_next[0].sector = SEC_BLUE;
            op_a = pix_data.red_in;
            op_b = pix_data.green_in;
        end
        stg_next[0].neg = (op_a < op_b);
        stg_next[0].mag = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);
    end

    // second stage: scale by 15360 and seed the divider
    always_comb
    begin
        stg_next[1] = stg_reg[0];
        scaled = ({6'd0, stg_reg[0].mag, 8'd0} << 6) - ({14'd0, stg_reg[0].mag} << 10);
        stg_next[1].rem = scaled[21:QUO_W];
        stg_next[1].dvd = scaled[QUO_W-1:0];
        stg_next[1].quo = '0;
    end

    // divider stages, two quotient bits each
    for (genvar k = 2; k < DIV_PIPE; k++)
    begin : g_div
        always_comb
        begin
            stg_next[k] = stg_reg[k-1];
            for (int j = 0; j < DIV_BITS; j++)
            begin
                stg_next[k] = div_step(stg_next[k]);
            end
        end
    end

    // hue stage: sector base plus or minus the quotient, zero for grey, wrap a negative red hue
    always_comb
    begin
        last    = stg_reg[DIV_PIPE-1];
        quo_ext = {{(17 - QUO_W){1'b0}}, last.quo};
        case (last.sector)
            SEC_RED:   base = HUE_BASE_RED;
            SEC_GREEN: base = HUE_BASE_GREEN;
            SEC_BLUE:  base = HUE_BASE_BLUE;
            default:   base = HUE_BASE_RED;
        endcase
        if (last.zero)
        begin
            hue_next = '0;
        end
        else if (!last.neg || quo_ext == '0)
        begin
            hue_next = base + quo_ext;
        end
        else if (base >= quo_ext)
        begin
            hue_next = base - quo_ext;
        end
        else
        begin
            hue_next = base + HUE_FULL - quo_ext;
        end
    end

    // output stage: range test against the keying bounds
    always_comb
    begin
        res_next.red_out   = hue_pix_reg.red_in;
        res_next.green_out = hue_pix_reg.green_in;
        res_next.blue_out  = hue_pix_reg.blue_in;
        res_next.hue_out   = hue_reg;
        res_next.alpha_out = (hue_reg >= hue_low_reg && hue_reg <= hue_high_reg)
                             ? ALPHA_KEYED : ALPHA_OPAQUE;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (en[NUM_STAGES])
            begin
                res_valid_reg <= vld_reg[NUM_STAGES-1];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_PIPE; k++)
        begin
            if (en[k])
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
        if (en[NUM_STAGES-1])
        begin
            hue_pix_reg <= stg_reg[DIV_PIPE-1].pix;
            hue_reg     <= hue_next;
        end
        if (en[NUM_STAGES])
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // grey result: all three channels equal
    logic res_grey;
    assign res_grey = (res_reg.red_out == res_reg.green_out)
                      && (res_reg.green_out == res_reg.blue_out);

    // checks
    `HRAK_ASSERT(a_hue_in_range, res_valid_reg |-> res_reg.hue_out < HUE_FULL)
    `HRAK_ASSERT(a_grey_hue_zero, (res_valid_reg && res_grey) |-> res_reg.hue_out == '0)
    `HRAK_ASSERT(a_stall_when_full, pix_stall |-> (vld_reg[0] && res_valid_reg))
    `HRAK_ASSERT_NEXT(a_held_result, (res_valid_reg && res_stall), (res_valid_reg && $stable(res_reg)))

endmodule

### tb/sv/testbench.sv
// self-checking testbench for hue_range_alpha_key: pixel requests in, keyed results out
// depends on hrak_pkg and the hue_range_alpha_key top level
// hue prediction and in-order result checking live in a small scoreboard class
`timescale 1ns / 100ps

module testbench;

    import hrak_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 30;
    localparam int REPORT_MAX = 10;
    localparam logic [16:0] HUE_TOP = 17'd92159;
    localparam logic [16:0] BOUND_MAX = 17'h1FFFF;

    // hand-picked pixels, 24'hRRGGBB
    localparam int DIRECTED_COUNT = 22;
    localparam logic [23:0] DIRECTED_PIXELS [DIRECTED_COUNT] = '{
        24'h000000, 24'hFFFFFF, 24'h010101, 24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF00FE, 24'h010000,
        24'h000100, 24'h000001, 24'hFFFE00, 24'h00FFFE, 24'hFE00FF, 24'h807F7F,
        24'hC86496, 24'hAA55FF, 24'h55AA00, 24'h00F055
    };

    // scoreboard: predicts each keyed result and checks results in order
    class hue_key_scoreboard;
        result_t keyed_q[$];
        logic [16:0] hue_low;
        logic [16:0] hue_high;
        int errors;

        function new();
            hue_low = HUE_LOW_RESET;
            hue_high = HUE_HIGH_RESET;
            errors = 0;
        endfunction

        function void set_bounds(logic [16:0] low_b, logic [16:0] high_b);
            hue_low = low_b;
            hue_high = high_b;
        endfunction

        // hue in 1/256 degree units; sector picked by the first channel at the maximum
        function logic [16:0] pixel_hue(pixel_t p);
            int r, g, b, top, bottom, base, num, h;
            r = p.red_in;
            g = p.green_in;
            b = p.blue_in;
            top = r;
            if (g > top) top = g;
            if (b > top) top = b;
            bottom = r;
            if (g < bottom) bottom = g;
            if (b < bottom) bottom = b;
            if (top == 0 || top == bottom)
                return 17'd0;
            if (r == top)
            begin
                base = HUE_BASE_RED;
                num = g - b;
            end
            else if (g == top)
            begin
                base = HUE_BASE_GREEN;
                num = b - r;
            end
            else
            begin
                base = HUE_BASE_BLUE;
                num = r - g;
            end
            // integer division truncates toward zero, negative red sector wraps
            h = base + (int'(HUE_SIXTY) * num) / (top - bottom);
            if (h < 0)
                h += int'(HUE_FULL);
            return h[16:0];
        endfunction

        function void note_pixel(pixel_t p);
            result_t want;
            want.red_out = p.red_in;
            want.green_out = p.green_in;
            want.blue_out = p.blue_in;
            want.hue_out = pixel_hue(p);
            if (want.hue_out >= hue_low && want.hue_out <= hue_high)
                want.alpha_out = ALPHA_KEYED;
            else
                want.alpha_out = ALPHA_OPAQUE;
            keyed_q.push_back(want);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (keyed_q.size() == 0)
            begin
                if (errors < REPORT_MAX)
                    $display("unexpected result with nothing pending: %h", got);
                errors++;
                return;
            end
            want = keyed_q.pop_front();
            if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
                got.blue_out !== want.blue_out || got.alpha_out !== want.alpha_out ||
                got.hue_out !== want.hue_out)
            begin
                if (errors < REPORT_MAX)
                    $display({"mismatch: expected rgb %0d %0d %0d alpha %0d hue %0d,",
                              " got rgb %0d %0d %0d alpha %0d hue %0d"},
                             want.red_out, want.green_out, want.blue_out, want.alpha_out,
                             want.hue_out, got.red_out, got.green_out, got.blue_out,
                             got.alpha_out, got.hue_out);
                errors++;
            end
        endfunction

        function int pending();
            return keyed_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pix_valid = 1'b0;
    logic pix_stall;
    pixel_t pix_data = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    result_t res_data;
    logic wr_en = 1'b0;
    logic wr_index = REG_HUE_LOW;
    logic [16:0] wr_data = '0;

    hue_key_scoreboard sb = new();

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int cycles = 0;

    hue_range_alpha_key i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: check accepted results, then pick the stall for the next cycle
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                sb.check_result(res_data);
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // offer one request, with random idle cycles ahead of it, and wait for acceptance
    task send_pixel(input pixel_t p);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_data <= p;
        pix_valid <= 1'b1;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        sb.note_pixel(p);
    endtask

    // both bounds, one per cycle, only while nothing is in flight
    task write_bounds(input logic [16:0] low_b, input logic [16:0] high_b);
        wr_en <= 1'b1;
        wr_index <= REG_HUE_LOW;
        wr_data <= low_b;
        @(posedge clk);
        wr_index <= REG_HUE_HIGH;
        wr_data <= high_b;
        @(posedge clk);
        wr_en <= 1'b0;
        sb.set_bounds(low_b, high_b);
    endtask

    task wait_drained();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // mostly random pixels, with greys, tied maxima, pure hues and dark pixels mixed in
    function automatic pixel_t random_pixel();
        pixel_t p;
        logic [7:0] top, bottom, any;
        p = 24'($urandom_range(0, 32'hFFFFFF));
        top = 8'($urandom_range(1, 255));
        bottom = 8'($urandom_range(0, top - 1));
        any = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            5: p = {top, top, top};
            6:
            begin
                case ($urandom_range(0, 2))
                    0: p = {top, top, bottom};
                    1: p = {top, bottom, top};
                    default: p = {bottom, top, top};
                endcase
            end
            7:
            begin
                case ($urandom_range(0, 5))
                    0: p = {8'd255, 8'd0, any};
                    1: p = {8'd255, any, 8'd0};
                    2: p = {8'd0, 8'd255, any};
                    3: p = {any, 8'd255, 8'd0};
                    4: p = {8'd0, any, 8'd255};
                    default: p = {any, 8'd0, 8'd255};
                endcase
            end
            8: p = {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                    8'($urandom_range(0, 3))};
            default: ;
        endcase
        return p;
    endfunction

    task run_random(input int count, input int idle_pct, input int stall_chance);
        send_idle_pct = idle_pct;
        stall_pct = stall_chance;
        repeat (count)
            send_pixel(random_pixel());
        wait_drained();
    endtask

    // main sequence
    initial
    begin
        pixel_t anchor;
        logic [16:0] anchor_hue;
        logic [16:0] low_b, high_b;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pixels under the reset bounds, no idling
        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_pixel(DIRECTED_PIXELS[i]);
        wait_drained();

        // only hue 0 keyed, steady streaming
        write_bounds(17'd0, 17'd0);
        run_random(110, 0, 0);

        // every hue keyed, sparse requests
        write_bounds(17'd0, HUE_TOP);
        run_random(110, 79, 0);

        // middle band, receiver mostly stalled
        write_bounds(17'd30000, HUE_BASE_BLUE);
        run_random(110, 0, 79);

        // bounds at the top and beyond, light idling on both sides
        write_bounds(HUE_TOP, BOUND_MAX);
        run_random(110, 9, 9);

        // inverted bounds; long receiver hold-off so the pipe fills and stalls its input
        write_bounds(17'd50000, 17'd40000);
        hold_left = 300;
        run_random(110, 0, 0);

        // bounds on and just off the hue of an anchor pixel
        for (int round = 0; round < 6; round++)
        begin
            anchor = random_pixel();
            anchor_hue = sb.pixel_hue(anchor);
            case (round % 3)
                0:
                begin
                    low_b = anchor_hue;
                    high_b = anchor_hue;
                end
                1:
                begin
                    low_b = anchor_hue + 17'd1;
                    high_b = BOUND_MAX;
                end
                default:
                begin
                    low_b = 17'd0;
                    high_b = (anchor_hue == 17'd0) ? 17'd0 : anchor_hue - 17'd1;
                end
            endcase
            write_bounds(low_b, high_b);
            send_idle_pct = 30;
            stall_pct = 30;
            repeat (25)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_pixel(anchor);
                else
                    send_pixel(random_pixel());
            end
            wait_drained();
        end

        // let any stray result show up before the verdict
        stall_pct = 0;
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
